[rtl/stins_pkg.sv]
// Shared types and constants for the sorted table with insert and remove.
// No dependencies; imported by the cell row, the top level and the checker.
package stins_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    // Operation codes carried by the kind field
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic                      ins;    // insert value at its sorted place
        logic                      shl;    // close a gap: cells at or above value shift down
        logic signed [VALUE_W-1:0] value;  // value under operation
    } t_cell_cmd;

endpackage : stins_pkg

[rtl/sorted_table_insert_remove.sv]
// Top level of the sorted table: control sequencer, entry count and the row of cells.
// Depends on stins_pkg and stins_cell.
//
//   channel  direction  handshake                   payload
//   input    in         i_in_valid / o_in_ready     i_kind, i_value
//   result   out        o_out_valid / i_out_ready   o_ok, o_entry_count
//
// Insert: in the accept cycle every cell compares and those above the value move up by one.
// Remove: the accept cycle latches the value; the row closes the run of equal entries one
// position per cycle, answered once no match is left. The input is held off throughout.
// Reset (synchronous, active low) empties the table and drops any pending result.
// A new item is taken only when the sequencer is idle and the result register is
// empty or being emptied in the same cycle; a stalled result holds its value.
module sorted_table_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic signed [stins_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_ok,
    output logic [stins_pkg::COUNT_OUT_W-1:0]    o_entry_count
);
    import stins_pkg::*;

    localparam int            CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_REMOVE = 1'b1;

    logic                      r_state;
    logic                      n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_found;
    logic                      n_found;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_ok;
    logic                      n_out_ok;
    logic signed [VALUE_W-1:0] r_value;

    logic                      accept;
    logic                      full;
    logic                      any_eq;
    t_cell_cmd                 cmd;

    logic signed [VALUE_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]       le_vec;
    logic [CAPACITY-1:0]       eq_vec;

    // Handshake and status
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CAP_C);
    assign any_eq     = |eq_vec;

    // Build the command for the row
    always_comb begin
        cmd.value = (r_state == S_REMOVE) ? r_value : i_value;
        cmd.ins   = accept && (i_kind == KIND_INSERT) && !full;
        cmd.shl   = (r_state == S_REMOVE) && any_eq;
    end

    // Row of cells, each wired to its neighbours
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [VALUE_W-1:0] left_entry;
        logic                      left_le;
        logic signed [VALUE_W-1:0] right_entry;

        if (k == 0) begin : g_first
            assign left_entry = '0;
            assign left_le    = 1'b1;
        end else begin : g_mid
            assign left_entry = entry[k-1];
            assign left_le    = le_vec[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entry[k+1];
        end

        stins_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_count       (r_count),
            .i_left_entry  (left_entry),
            .i_left_le     (left_le),
            .i_right_entry (right_entry),
            .o_entry       (entry[k]),
            .o_le          (le_vec[k]),
            .o_eq          (eq_vec[k])
        );
    end

    // Sequencer: insert answers at once, remove loops until no match is left
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_ok    = r_out_ok;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_INSERT) begin
                        n_out_valid = 1'b1;
                        n_out_ok    = !full;
                        if (!full) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_state = S_REMOVE;
                        n_found = 1'b0;
                    end
                end
            end
            S_REMOVE: begin
                if (any_eq) begin
                    n_count = r_count - CNT_W'(1);
                    n_found = 1'b1;
                end else begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_ok    = r_found;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: hold the remove value and the result flag
    always_ff @(posedge i_clk) begin
        r_out_ok <= n_out_ok;
        if (accept) begin
            r_value <= i_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_entry_count = COUNT_OUT_W'(r_count);

endmodule : sorted_table_insert_remove

[rtl/stins_cell.sv]
// One cell of the sorted row: holds a single entry and trades it with its neighbours.
// Depends on stins_pkg for the command struct and value width.
module stins_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                               i_clk,
    input  stins_pkg::t_cell_cmd               i_cmd,
    input  logic [CNT_W-1:0]                   i_count,
    input  logic signed [stins_pkg::VALUE_W-1:0] i_left_entry,
    input  logic                               i_left_le,
    input  logic signed [stins_pkg::VALUE_W-1:0] i_right_entry,
    output logic signed [stins_pkg::VALUE_W-1:0] o_entry,
    output logic                               o_le,
    output logic                               o_eq
);
    import stins_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;
    logic                      valid;
    logic                      ge;

    // Occupied when this position lies below the entry count
    assign valid = (CNT_W'(IDX) < i_count);

    // Compare the held entry against the broadcast value
    assign o_le = valid && (r_entry <= i_cmd.value);
    assign o_eq = valid && (r_entry == i_cmd.value);
    assign ge   = valid && (r_entry >= i_cmd.value);

    // Keep, take the new value, take the left entry, or take the right entry
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && !o_le) begin
            n_entry = i_left_le ? i_cmd.value : i_left_entry;
        end else if (i_cmd.shl && ge) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule : stins_cell

[rtl/stins_checker.sv]
// Port-level checks for the sorted table, attached to the top level by bind.
// Depends on stins_pkg for field widths.
module stins_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 i_kind,
    input logic signed [stins_pkg::VALUE_W-1:0] i_value,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_ok,
    input logic [stins_pkg::COUNT_OUT_W-1:0]    o_entry_count
);
    import stins_pkg::*;

    // A waiting input item holds its fields
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_kind) && $stable(i_value))
        else $error("input item changed while waiting");

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ok) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // No new item while a result waits untaken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item accepted over a pending result");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Count never exceeds the capacity where it fits the field
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 31) || (int'(o_entry_count) <= CAPACITY))
        else $error("entry count above capacity");

endmodule : stins_checker

bind sorted_table_insert_remove stins_checker #(.CAPACITY(CAPACITY)) u_stins_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_kind        (i_kind),
    .i_value       (i_value),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_ok          (o_ok),
    .o_entry_count (o_entry_count)
);
